### src/polyrem_pkg.sv
// ============================================================================
// polyrem_pkg
// Shared widths, codes and controller/datapath interface types for the
// integer polynomial remainder block.
// ============================================================================
`default_nettype none

package polyrem_pkg;

   localparam int MAX_DEGREE_DEF = 31;
   localparam int COEF_W         = 16;
   localparam int WORK_W         = 32;
   localparam int DEG_W          = 6;
   localparam int STATUS_W       = 2;

   localparam logic ACTION_DIVIDEND = 1'b0;
   localparam logic ACTION_DIVISOR  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_LEAD_ZERO = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic top_init;
      logic top_inc;
      logic j_init;
      logic j_inc;
      logic emit_init;
      logic row_rd;
      logic div_start;
      logic tap_rd;
      logic tap_mul;
      logic tap_wr;
      logic emit_rd;
      logic emit_load;
      logic err_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_final_div;
      logic error;
      logic empty;
      logic n_ge_m;
      logic div_done;
      logic tap_last;
      logic row_last;
      logic emit_last;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

### src/polyrem_ram.sv
// ============================================================================
// polyrem_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module polyrem_ram #(
   parameter int WIDTH = polyrem_pkg::WORK_W,
   parameter int DEPTH = polyrem_pkg::MAX_DEGREE_DEF + 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/polyrem_div.sv
// ============================================================================
// polyrem_div
// Iterative signed divider, 32-bit dividend by 16-bit divisor, one quotient
// bit per cycle, quotient truncated toward zero and wrapped to 32 bits.
// ============================================================================
`default_nettype none

module polyrem_div (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [polyrem_pkg::WORK_W-1:0]  dividend,
   input  wire logic signed [polyrem_pkg::COEF_W-1:0]  divisor,
   output logic                                        done,
   output logic             [polyrem_pkg::WORK_W-1:0]  quotient
);

   import polyrem_pkg::*;

   localparam int CNT_W = $clog2(WORK_W + 1);

   logic              busy_ff, busy_in;
   logic              fix_ff, fix_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COEF_W-1:0] rem_ff, rem_in;
   logic [WORK_W-1:0] quo_ff, quo_in;
   logic [COEF_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;

   logic [COEF_W:0]   rem_sh;
   logic [COEF_W:0]   rem_diff;
   logic              ge;

   assign rem_sh   = {rem_ff, quo_ff[WORK_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign ge       = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WORK_W);
         rem_in  = '0;
         quo_in  = dividend[WORK_W-1] ? (~$unsigned(dividend) + WORK_W'(1))
                                      : $unsigned(dividend);
         dvs_in  = divisor[COEF_W-1] ? (~$unsigned(divisor) + COEF_W'(1))
                                     : $unsigned(divisor);
         neg_in  = dividend[WORK_W-1] ^ divisor[COEF_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? rem_diff[COEF_W-1:0] : rem_sh[COEF_W-1:0];
         quo_in = {quo_ff[WORK_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         quo_in  = neg_ff ? (~quo_ff + WORK_W'(1)) : quo_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### src/polyrem_dp.sv
// ============================================================================
// polyrem_dp
// Datapath: coefficient stores, load counters and flags, row/tap/emit
// indexes, shared divider, multiply-subtract and the result register.
// ============================================================================
`default_nettype none

module polyrem_dp #(
   parameter int MAX_DEGREE = polyrem_pkg::MAX_DEGREE_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire polyrem_pkg::cmd_type                    cmd,
   output polyrem_pkg::sts_type                         sts,
   input  wire logic                                    req_action,
   input  wire logic signed [polyrem_pkg::COEF_W-1:0]   req_coefficient,
   input  wire logic                                    req_final_coef,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic signed [polyrem_pkg::WORK_W-1:0]        rsp_remainder_coef,
   output logic        [polyrem_pkg::DEG_W-1:0]         rsp_degree,
   output logic                                         rsp_last_out,
   output logic        [polyrem_pkg::STATUS_W-1:0]      rsp_status
);

   import polyrem_pkg::*;

   localparam int CAP = MAX_DEGREE + 1;
   localparam int AW  = $clog2(CAP);
   localparam int CW  = $clog2(CAP + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAP);

   logic [CW-1:0]            dvd_cnt_ff, dvd_cnt_in;
   logic [CW-1:0]            dvs_cnt_ff, dvs_cnt_in;
   logic                     ovf_ff, ovf_in;
   logic                     done_ff, done_in;
   logic signed [COEF_W-1:0] lead_ff;
   logic [AW-1:0]            top_ff, top_in;
   logic [AW-1:0]            j_ff, j_in;
   logic [AW-1:0]            d_ff, d_in;
   logic [WORK_W-1:0]        prod_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORK_W-1:0]        rsp_coef_ff;
   logic [DEG_W-1:0]         rsp_degree_ff;
   logic                     rsp_last_ff;
   status_type               rsp_status_ff;

   logic [CW-1:0]            dvd_idx;
   logic                     dvd_fits;
   logic                     dvs_fits;
   logic                     load_dvd;
   logic                     load_dvs;
   logic [AW-1:0]            tap_addr;
   logic [CW-1:0]            emit_idx;
   status_type               err_status;

   logic                     dvd_we;
   logic [AW-1:0]            dvd_waddr;
   logic [WORK_W-1:0]        dvd_wdata;
   logic                     dvd_re;
   logic [AW-1:0]            dvd_raddr;
   logic [WORK_W-1:0]        ws_rd;
   logic [COEF_W-1:0]        dvs_rd;

   logic                     div_done;
   logic [WORK_W-1:0]        quotient;
   logic signed [WORK_W+COEF_W-1:0] prod_full;

   assign load_dvd = cmd.load && (req_action == ACTION_DIVIDEND);
   assign load_dvs = cmd.load && (req_action == ACTION_DIVISOR);
   assign dvd_idx  = done_ff ? '0 : dvd_cnt_ff;
   assign dvd_fits = dvd_idx != CAP_C;
   assign dvs_fits = dvs_cnt_ff != CAP_C;
   assign tap_addr = top_ff + j_ff;
   assign emit_idx = dvd_cnt_ff - CW'(1) - CW'(d_ff);

   always_comb begin
      if (ovf_ff) begin
         err_status = STATUS_OVERFLOW;
      end else if (lead_ff == '0) begin
         err_status = STATUS_LEAD_ZERO;
      end else begin
         err_status = STATUS_OK;
      end
   end

   // load counters and problem flags
   always_comb begin
      dvd_cnt_in = dvd_cnt_ff;
      dvs_cnt_in = dvs_cnt_ff;
      ovf_in     = ovf_ff;
      done_in    = done_ff;
      if (cmd.clear) begin
         dvd_cnt_in = '0;
         dvs_cnt_in = '0;
         ovf_in     = 1'b0;
         done_in    = 1'b0;
      end else if (load_dvd) begin
         dvd_cnt_in = dvd_fits ? (dvd_idx + CW'(1)) : dvd_idx;
         ovf_in     = (done_ff ? 1'b0 : ovf_ff) | !dvd_fits;
         dvs_cnt_in = done_ff ? '0 : dvs_cnt_ff;
         done_in    = req_final_coef;
      end else if (load_dvs) begin
         if (dvs_fits) begin
            dvs_cnt_in = dvs_cnt_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // row, tap and emit indexes
   always_comb begin
      top_in = top_ff;
      j_in   = j_ff;
      d_in   = d_ff;
      if (cmd.top_init) begin
         top_in = '0;
      end else if (cmd.top_inc) begin
         top_in = top_ff + AW'(1);
      end
      if (cmd.j_init) begin
         j_in = '0;
      end else if (cmd.j_inc) begin
         j_in = j_ff + AW'(1);
      end
      if (cmd.emit_init) begin
         d_in = '0;
      end else if (cmd.emit_load) begin
         d_in = d_ff + AW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load || cmd.err_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvd_cnt_ff   <= '0;
         dvs_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
         done_ff      <= 1'b0;
         top_ff       <= '0;
         j_ff         <= '0;
         d_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dvd_cnt_ff   <= dvd_cnt_in;
         dvs_cnt_ff   <= dvs_cnt_in;
         ovf_ff       <= ovf_in;
         done_ff      <= done_in;
         top_ff       <= top_in;
         j_ff         <= j_in;
         d_ff         <= d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_dvs && (dvs_cnt_ff == '0)) begin
         lead_ff <= req_coefficient;
      end
      if (cmd.tap_mul) begin
         prod_ff <= prod_full[WORK_W-1:0];
      end
      if (cmd.emit_load) begin
         rsp_coef_ff   <= ws_rd;
         rsp_degree_ff <= DEG_W'(d_ff);
         rsp_last_ff   <= sts.emit_last;
         rsp_status_ff <= STATUS_OK;
      end else if (cmd.err_load) begin
         rsp_coef_ff   <= '0;
         rsp_degree_ff <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= err_status;
      end
   end

   // working dividend store
   assign dvd_we    = (load_dvd && dvd_fits) || cmd.tap_wr;
   assign dvd_waddr = cmd.tap_wr ? tap_addr : dvd_idx[AW-1:0];
   assign dvd_wdata = cmd.tap_wr ? (ws_rd - prod_ff) : WORK_W'(req_coefficient);
   assign dvd_re    = cmd.row_rd || cmd.tap_rd || cmd.emit_rd;
   assign dvd_raddr = cmd.row_rd ? top_ff : (cmd.tap_rd ? tap_addr : emit_idx[AW-1:0]);

   polyrem_ram #(
      .WIDTH (WORK_W),
      .DEPTH (CAP)
   ) u_dvd_ram (
      .clock   (clock),
      .wr_en   (dvd_we),
      .wr_addr (dvd_waddr),
      .wr_data (dvd_wdata),
      .rd_en   (dvd_re),
      .rd_addr (dvd_raddr),
      .rd_data (ws_rd)
   );

   polyrem_ram #(
      .WIDTH (COEF_W),
      .DEPTH (CAP)
   ) u_dvs_ram (
      .clock   (clock),
      .wr_en   (load_dvs && dvs_fits),
      .wr_addr (dvs_cnt_ff[AW-1:0]),
      .wr_data (req_coefficient),
      .rd_en   (cmd.tap_rd),
      .rd_addr (j_ff),
      .rd_data (dvs_rd)
   );

   polyrem_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ($signed(ws_rd)),
      .divisor  (lead_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign prod_full = $signed(quotient) * $signed(dvs_rd);

   assign sts.req_final_div = (req_action == ACTION_DIVISOR) && req_final_coef;
   assign sts.error         = err_status != STATUS_OK;
   assign sts.empty         = dvd_cnt_ff == '0;
   assign sts.n_ge_m        = dvd_cnt_ff >= dvs_cnt_ff;
   assign sts.div_done      = div_done;
   assign sts.tap_last      = (CW'(j_ff) + CW'(1)) == dvs_cnt_ff;
   assign sts.row_last      = (CW'(top_ff) + dvs_cnt_ff) == dvd_cnt_ff;
   assign sts.emit_last     = (CW'(d_ff) + CW'(1)) == dvd_cnt_ff;
   assign sts.rsp_free      = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_remainder_coef = $signed(rsp_coef_ff);
   assign rsp_degree         = rsp_degree_ff;
   assign rsp_last_out       = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire

### src/polyrem_ctrl.sv
// ============================================================================
// polyrem_ctrl
// Controller: sequences loading, per-row divide, per-tap multiply-subtract
// and result emission through command and status structs.
// ============================================================================
`default_nettype none

module polyrem_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire polyrem_pkg::sts_type  sts,
   output polyrem_pkg::cmd_type       cmd
);

   import polyrem_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_CHECK    = 11'b000_0000_0010,
      S_ROW_RD   = 11'b000_0000_0100,
      S_ROW_LD   = 11'b000_0000_1000,
      S_DIV      = 11'b000_0001_0000,
      S_TAP_RD   = 11'b000_0010_0000,
      S_TAP_MUL  = 11'b000_0100_0000,
      S_TAP_WR   = 11'b000_1000_0000,
      S_EMIT_RD  = 11'b001_0000_0000,
      S_EMIT_OUT = 11'b010_0000_0000,
      S_ERR_OUT  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.req_final_div) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (sts.error || sts.empty) begin
               state_in = S_ERR_OUT;
            end else if (sts.n_ge_m) begin
               cmd.top_init = 1'b1;
               state_in     = S_ROW_RD;
            end else begin
               cmd.emit_init = 1'b1;
               state_in      = S_EMIT_RD;
            end
         end
         S_ROW_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = S_ROW_LD;
         end
         S_ROW_LD: begin
            cmd.div_start = 1'b1;
            cmd.j_init    = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_TAP_RD;
            end
         end
         S_TAP_RD: begin
            cmd.tap_rd = 1'b1;
            state_in   = S_TAP_MUL;
         end
         S_TAP_MUL: begin
            cmd.tap_mul = 1'b1;
            state_in    = S_TAP_WR;
         end
         S_TAP_WR: begin
            cmd.tap_wr = 1'b1;
            if (!sts.tap_last) begin
               cmd.j_inc = 1'b1;
               state_in  = S_TAP_RD;
            end else if (sts.row_last) begin
               cmd.emit_init = 1'b1;
               state_in      = S_EMIT_RD;
            end else begin
               cmd.top_inc = 1'b1;
               state_in    = S_ROW_RD;
            end
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (sts.rsp_free) begin
               cmd.emit_load = 1'b1;
               if (sts.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_ERR_OUT: begin
            if (sts.rsp_free) begin
               cmd.err_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

`default_nettype wire

### src/polynomial_remainder_integer.sv
// Coefficient loads are accepted only while the controller is idle; a new transaction is taken while a result waits.
// Divisor end: a check state, then, when n >= m, (n-m+1) rows, each a divide
// (a 32-step shared divider) and a read-multiply-write pass per divisor tap on one RAM port,
// then a read and an output step per emitted coefficient; n, m are the dividend and divisor lengths.
// Reset is synchronous, active high; it clears counts and flags, the stores are not cleared.
// ============================================================================
// polynomial_remainder_integer
// Integer polynomial long division; emits the remainder coefficients from
// degree 0 upward, or one error/empty transaction.
// ============================================================================
`default_nettype none

module polynomial_remainder_integer #(
   parameter int MAX_DEGREE = polyrem_pkg::MAX_DEGREE_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_action,
   input  wire logic signed [polyrem_pkg::COEF_W-1:0]   req_coefficient,
   input  wire logic                                    req_final_coef,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic signed [polyrem_pkg::WORK_W-1:0]        rsp_remainder_coef,
   output logic        [polyrem_pkg::DEG_W-1:0]         rsp_degree,
   output logic                                         rsp_last_out,
   output logic        [polyrem_pkg::STATUS_W-1:0]      rsp_status
);

   import polyrem_pkg::*;

   cmd_type cmd;
   sts_type sts;

   polyrem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   polyrem_dp #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_coefficient    (req_coefficient),
      .req_final_coef     (req_final_coef),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_remainder_coef (rsp_remainder_coef),
      .rsp_degree         (rsp_degree),
      .rsp_last_out       (rsp_last_out),
      .rsp_status         (rsp_status)
   );

`ifndef SYNTHESIS
   a_err_format : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
         (rsp_last_out && (rsp_degree == '0) && (rsp_remainder_coef == '0)))
      else $error("error transaction not a single zero coefficient");

   a_final_blocks : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ACTION_DIVISOR) && req_final_coef)
         |=> !req_ready)
      else $error("transaction taken right after divisor end");

   a_tap_order : assert property (@(posedge clock) disable iff (reset)
      cmd.tap_wr |-> $past(cmd.tap_mul))
      else $error("tap write without preceding multiply");
`endif

endmodule

`default_nettype wire

### verif/tb_polynomial_remainder_integer.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_polynomial_remainder_integer
// Loads dividend and divisor coefficient streams into the remainder block and
// predicts every emitted coefficient with an independent long-division model.
// Both handshakes are throttled at random, and the result side is held off long
// enough to back the input up. Directed problems cover the lead-zero and empty
// cases; random problems follow, the first two overflowing dividend and divisor.
// ============================================================================

typedef struct packed {
   logic [31:0]              coef;
   logic [5:0]               degree;
   logic                     last;
   polyrem_pkg::status_type  status;
} remainder_type;

class remainder_tracker;
   logic [31:0] work_coef[32];
   logic [15:0] divisor_coef[32];
   int unsigned work_len;
   int unsigned divisor_len;
   bit too_many;
   bit dividend_closed;
   remainder_type due_coefs[$];
   int errors;
   int received;

   function new();
      foreach (work_coef[i]) work_coef[i] = '0;
      foreach (divisor_coef[i]) divisor_coef[i] = '0;
      restart();
   endfunction

   function void restart();
      work_len = 0;
      divisor_len = 0;
      too_many = 0;
      dividend_closed = 0;
   endfunction

   function void push(logic [31:0] c, int unsigned d, bit l, polyrem_pkg::status_type s);
      remainder_type r;
      r.coef = c;
      r.degree = d[5:0];
      r.last = l;
      r.status = s;
      due_coefs.push_back(r);
   endfunction

   function void note_coef(logic act, logic [15:0] c, logic fin);
      longint q64;
      logic [31:0] q;
      logic [31:0] tap;
      polyrem_pkg::status_type st;
      if (act == polyrem_pkg::ACTION_DIVIDEND) begin
         if (dividend_closed) restart();
         if (work_len < 32) begin
            work_coef[work_len] = {{16{c[15]}}, c};
            work_len++;
         end else begin
            too_many = 1;
         end
         if (fin) dividend_closed = 1;
         return;
      end
      if (divisor_len < 32) begin
         divisor_coef[divisor_len] = c;
         divisor_len++;
      end else begin
         too_many = 1;
      end
      if (!fin) return;
      if (too_many) st = polyrem_pkg::STATUS_OVERFLOW;
      else if (divisor_coef[0] == 16'd0) st = polyrem_pkg::STATUS_LEAD_ZERO;
      else st = polyrem_pkg::STATUS_OK;
      if (st != polyrem_pkg::STATUS_OK || work_len == 0) begin
         push('0, 0, 1'b1, st);
         restart();
         return;
      end
      if (work_len >= divisor_len) begin
         for (int unsigned top = 0; top <= work_len - divisor_len; top++) begin
            q64 = longint'($signed(work_coef[top])) / longint'($signed(divisor_coef[0]));
            q = q64[31:0];
            for (int unsigned j = 0; j < divisor_len; j++) begin
               tap = {{16{divisor_coef[j][15]}}, divisor_coef[j]};
               work_coef[top + j] = work_coef[top + j] - q * tap;
            end
         end
      end
      for (int unsigned d = 0; d < work_len; d++)
         push(work_coef[work_len - 1 - d], d, d == work_len - 1, polyrem_pkg::STATUS_OK);
      restart();
   endfunction

   task report(string what);
      $display("ERROR @%0t: %s", $time, what);
      errors++;
   endtask

   task check_coef(logic [31:0] c, logic [5:0] d, logic l, logic [1:0] s);
      remainder_type r;
      received++;
      if (due_coefs.size() == 0) begin
         report($sformatf("unexpected transaction coef=%0d degree=%0d", $signed(c), d));
         return;
      end
      r = due_coefs.pop_front();
      if (c !== r.coef)
         report($sformatf("degree %0d coef %0d, want %0d", r.degree, $signed(c),
                          $signed(r.coef)));
      if (d !== r.degree) report($sformatf("degree %0d, want %0d", d, r.degree));
      if (l !== r.last) report($sformatf("degree %0d last_out %b, want %b", r.degree, l, r.last));
      if (s !== r.status) report($sformatf("status %0d, want %0d", s, r.status));
   endtask
endclass

module tb_polynomial_remainder_integer;
   import polyrem_pkg::*;

   typedef enum int {
      PLAIN, DIVIDEND_OVER, DIVISOR_OVER, LEAD_ZERO, NO_DIVIDEND, EARLY_DIVISOR, RESTART
   } problem_kind_type;

   localparam logic [15:0] STALL_PATTERN = 16'b1101_1001_1110_0101;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_action = ACTION_DIVIDEND;
   logic signed [COEF_W-1:0] req_coefficient = '0;
   logic req_final_coef = 1'b0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [WORK_W-1:0] rsp_remainder_coef;
   logic [DEG_W-1:0] rsp_degree;
   logic rsp_last_out;
   logic [STATUS_W-1:0] rsp_status;

   remainder_tracker tracker = new();
   int coefs_sent = 0;
   int burst_left = 0;

   polynomial_remainder_integer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_coefficient    (req_coefficient),
      .req_final_coef     (req_final_coef),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_remainder_coef (rsp_remainder_coef),
      .rsp_degree         (rsp_degree),
      .rsp_last_out       (rsp_last_out),
      .rsp_status         (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_coef(rsp_remainder_coef, rsp_degree, rsp_last_out, rsp_status);
   end

   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

   // receiver: modes of random length, one long hold once results are flowing
   initial begin
      int span;
      int mode;
      int cyc;
      bit held;
      cyc = 0;
      held = 0;
      forever begin
         span = $urandom_range(40, 200);
         mode = $urandom_range(0, 2);
         repeat (span) begin
            @(negedge clock);
            cyc++;
            if (!held && !reset && rsp_valid && tracker.received >= 30) begin
               held = 1;
               rsp_ready <= 1'b0;
               repeat (300) @(negedge clock);
            end else begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_ready <= STALL_PATTERN[cyc % 16];
               endcase
            end
         end
      end
   end

   task automatic offer_coef(logic act, logic signed [15:0] c, logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_coefficient <= c;
      req_final_coef <= fin;
      do @(posedge clock); while (!req_ready);
      tracker.note_coef(act, c, fin);
      coefs_sent++;
   endtask

   task automatic send_list(logic act, logic signed [15:0] coefs[$], bit ends);
      foreach (coefs[i]) offer_coef(act, coefs[i], ends && (i == coefs.size() - 1));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.due_coefs.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_coef();
      logic signed [15:0] edges[5];
      edges = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd1};
      case ($urandom_range(0, 9))
         0, 1: return edges[$urandom_range(0, 4)];
         2, 3, 4: return 16'($signed($urandom_range(0, 16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_lead();
      logic signed [15:0] c;
      if ($urandom_range(0, 4) < 2) begin
         c = 16'($signed($urandom_range(0, 6)) - 3);
         return (c == 0) ? 16'sd1 : c;
      end
      do c = rand_coef(); while (c == 0);
      return c;
   endfunction

   function automatic problem_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 64) return PLAIN;
      if (r < 70) return DIVIDEND_OVER;
      if (r < 76) return DIVISOR_OVER;
      if (r < 82) return LEAD_ZERO;
      if (r < 88) return NO_DIVIDEND;
      if (r < 94) return EARLY_DIVISOR;
      return RESTART;
   endfunction

   task automatic random_problem(problem_kind_type kind);
      logic signed [15:0] num[$];
      logic signed [15:0] den[$];
      int n;
      int m;
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      m = $urandom_range(1, n + 1);
      if (m > 32) m = 32;
      if (kind == DIVIDEND_OVER) n = $urandom_range(33, 35);
      if (kind == DIVISOR_OVER) m = $urandom_range(33, 35);
      repeat (n) num.push_back(rand_coef());
      den.push_back((kind == LEAD_ZERO) ? 16'sd0 : rand_lead());
      repeat (m - 1) den.push_back(rand_coef());
      case (kind)
         NO_DIVIDEND: send_list(ACTION_DIVISOR, den, 1);
         EARLY_DIVISOR: begin
            send_list(ACTION_DIVIDEND, num, 0);
            send_list(ACTION_DIVISOR, den, 1);
         end
         RESTART: begin
            send_list(ACTION_DIVIDEND, num, 1);
            send_list(ACTION_DIVISOR, den, 0);
            num.reverse();
            send_list(ACTION_DIVIDEND, num, 1);
            send_list(ACTION_DIVISOR, den, 1);
         end
         default: begin
            send_list(ACTION_DIVIDEND, num, 1);
            send_list(ACTION_DIVISOR, den, 1);
         end
      endcase
   endtask

   initial begin
      int base;
      int p;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no dividend loaded
      send_list(ACTION_DIVISOR, '{16'sd5}, 1);
      // zero divisor lead
      send_list(ACTION_DIVIDEND, '{16'sd3}, 1);
      send_list(ACTION_DIVISOR, '{16'sd0, 16'sd7}, 1);
      // dividend lower than divisor
      send_list(ACTION_DIVIDEND, '{16'sd1, 16'sd2}, 1);
      send_list(ACTION_DIVISOR, '{16'sd1, 16'sd1, 16'sd1}, 1);
      // field extremes
      send_list(ACTION_DIVIDEND, '{16'sh8000, 16'sh7fff}, 1);
      send_list(ACTION_DIVISOR, '{-16'sd1}, 1);
      send_list(ACTION_DIVIDEND, '{16'sh8000, 16'sd0, 16'sh7fff, 16'sd1}, 1);
      send_list(ACTION_DIVISOR, '{16'sh7fff, 16'sh8000}, 1);
      // divisor before dividend end
      send_list(ACTION_DIVIDEND, '{16'sd4, 16'sd6}, 0);
      send_list(ACTION_DIVISOR, '{16'sd2, 16'sd3}, 1);
      // new dividend drops a partial divisor
      send_list(ACTION_DIVIDEND, '{16'sd9}, 1);
      send_list(ACTION_DIVISOR, '{16'sd1}, 0);
      send_list(ACTION_DIVIDEND, '{16'sd2, 16'sd5}, 1);
      send_list(ACTION_DIVISOR, '{16'sd1, 16'sd1}, 1);
      drain();

      base = coefs_sent;
      p = 0;
      while (coefs_sent - base < 250) begin
         case (p)
            0: random_problem(DIVIDEND_OVER);
            1: random_problem(DIVISOR_OVER);
            default: random_problem(pick_kind());
         endcase
         if (p == 8) drain();
         p++;
      end

      drain();
      repeat (60) @(posedge clock);
      if (tracker.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
